// ----- rtl/core/mad_pkg.sv -----
`default_nettype none
package mad_pkg;
    localparam int SAMPLE_BITS = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int COEF_BITS = 24;
    localparam int THR_BITS = 16;
    localparam int RUN_BITS = 8;
    localparam int ENERGY_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_RUN   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_ENERGY = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd7;

    // Control from sequencer to the cell row
    typedef struct packed {
        logic clear;   // forget all cells (unused cells compare as larger than any key)
        logic insert;  // insert key into sorted row (shift up)
        logic remove;  // remove key from sorted row (shift down)
    } row_ctrl_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FILT   = 7'b0000010,
        ST_UPD    = 7'b0000100,
        ST_MED    = 7'b0001000,
        ST_MAD    = 7'b0010000,
        ST_DECIDE = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

// ----- rtl/core/mad_cell.sv -----
`default_nettype none
// One slot of the sorted window row. Keeps the row ascending; a cell
// takes its lower neighbor or the key on insert and its upper neighbor on remove.
module mad_cell
    import mad_pkg::*;
#(
    parameter int W = 24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire row_ctrl_t     ctrl,
    input  wire logic [W-1:0]  key,
    input  wire logic          lo_full,
    input  wire logic [W-1:0]  lo_val,
    input  wire logic          lo_gt,     // lower neighbor > key
    input  wire logic          lo_eqm,    // removal point is at or below lower cell
    input  wire logic          hi_full,
    input  wire logic [W-1:0]  hi_val,
    output logic               full,
    output logic [W-1:0]       val,
    output logic               gt,
    output logic               eqm
);
    logic           full_reg, full_next;
    logic [W-1:0]   val_reg, val_next;
    logic           eq;

    // Empty cells behave as +infinity
    assign gt  = !full_reg || ($signed(val_reg) > $signed(key));
    assign eq  = full_reg && (val_reg == key);
    assign eqm = lo_eqm || eq;

    always_comb
    begin
        full_next = full_reg;
        val_next  = val_reg;
        if (ctrl.clear)
        begin
            full_next = 1'b0;
        end
        else if (ctrl.insert)
        begin
            if (gt)
            begin
                full_next = 1'b1;
                if (lo_gt)
                begin
                    val_next = lo_val;
                    full_next = lo_full;
                end
                else
                begin
                    val_next = key;
                end
            end
        end
        else if (ctrl.remove)
        begin
            if (eqm)
            begin
                val_next  = hi_val;
                full_next = hi_full;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign full = full_reg;
    assign val  = val_reg;
endmodule
`default_nettype wire

// ----- rtl/core/mad_row.sv -----
`default_nettype none
// Chain of sorted cells; lower index holds the smaller value.
module mad_row
    import mad_pkg::*;
#(
    parameter int W = 24,
    parameter int N = 65
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire row_ctrl_t     ctrl,
    input  wire logic [W-1:0]  key,
    output logic [W-1:0]       vals [N]
);
    logic         full_w [N];
    logic [W-1:0] val_w  [N];
    logic         gt_w   [N];
    logic         eqm_w  [N];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic         lo_full_i, lo_gt_i, lo_eqm_i, hi_full_i;
        logic [W-1:0] lo_val_i, hi_val_i;
        if (i == 0)
        begin : g_bot
            assign lo_full_i = 1'b0;
            assign lo_val_i  = '0;
            assign lo_gt_i   = 1'b0;
            assign lo_eqm_i  = 1'b0;
        end
        else
        begin : g_mid
            assign lo_full_i = full_w[i-1];
            assign lo_val_i  = val_w[i-1];
            assign lo_gt_i   = gt_w[i-1];
            assign lo_eqm_i  = eqm_w[i-1];
        end
        if (i == N-1)
        begin : g_top
            assign hi_full_i = 1'b0;
            assign hi_val_i  = '0;
        end
        else
        begin : g_low
            assign hi_full_i = full_w[i+1];
            assign hi_val_i  = val_w[i+1];
        end
        mad_cell #(.W(W)) u_cell (
            .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .key(key),
            .lo_full(lo_full_i), .lo_val(lo_val_i), .lo_gt(lo_gt_i), .lo_eqm(lo_eqm_i),
            .hi_full(hi_full_i), .hi_val(hi_val_i),
            .full(full_w[i]), .val(val_w[i]), .gt(gt_w[i]), .eqm(eqm_w[i])
        );
        assign vals[i] = val_w[i];
    end
endmodule
`default_nettype wire

// ----- rtl/core/mad_click_detector_core.sv -----
`default_nettype none
// MAD click detector.
// Input: s_axis, tdata[23:0] = audio_in (signed SAMPLE_BITS sample).
// Output: m_axis, one transfer per input; tdata[0] = click_found,
// tdata[1] = candidate flag. Config: cfg_we/cfg_idx/cfg_data, write when idle.
// Timing: one sample at a time. While the window fills, a sample passes the
// filter, the row update (window write, then insert new) and the output
// state, which sets m_axis_tvalid; the next input is taken only once the
// result has been taken and the block is back in idle.
// With a full window the row update also removes the oldest entry, and the
// median read, the outward MAD walk over the sorted cell row and the decision
// follow before the output state.
// Reset clears filter history, window fill state, run state and loads the
// default registers. The result is held in an output register; while the
// receiver stalls, the block finishes its current sample and waits there,
// s_axis_tready stays low until the result has been taken.
module mad_click_detector_core
    import mad_pkg::*;
#(
    parameter int HALF_WINDOW = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // audio_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // click_found, candidate flag, zeros
    input  wire logic        cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);
    localparam int N  = 2*HALF_WINDOW + 1;
    localparam int AW = $clog2(N);
    localparam int CW = $clog2(N+1);
    localparam int W  = SAMPLE_BITS;
    localparam int DW = W + 1;
    localparam int PW = THR_BITS + DW;

    // configuration
    logic [THR_BITS-1:0]    thr_reg;
    logic [RUN_BITS-1:0]    maxrun_reg;
    logic [ENERGY_BITS-1:0] minen_reg;
    logic signed [COEF_BITS-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= 16'd1792;
            maxrun_reg <= 8'd36;
            minen_reg  <= '0;
            b0_reg     <= 24'sd392156;
            b1_reg     <= -24'sd784312;
            b2_reg     <= 24'sd392156;
            a1_reg     <= -24'sd322510;
            a2_reg     <= 24'sd197531;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_THRESHOLD:  thr_reg    <= cfg_data[THR_BITS-1:0];
                REG_MAX_RUN:    maxrun_reg <= cfg_data[RUN_BITS-1:0];
                REG_MIN_ENERGY: minen_reg  <= cfg_data;
                REG_B0:         b0_reg     <= cfg_data[COEF_BITS-1:0];
                REG_B1:         b1_reg     <= cfg_data[COEF_BITS-1:0];
                REG_B2:         b2_reg     <= cfg_data[COEF_BITS-1:0];
                REG_A1:         a1_reg     <= cfg_data[COEF_BITS-1:0];
                REG_A2:         a2_reg     <= cfg_data[COEF_BITS-1:0];
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic signed [W-1:0] x_reg, x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [51:0]  acc_reg;
    logic [2:0]          tap_reg;
    logic [AW-1:0]       wptr_reg;
    logic [CW-1:0]       fill_reg;
    logic                run_reg;
    logic [RUN_BITS-1:0] rlen_reg;
    logic [ENERGY_BITS-1:0] ren_reg;
    logic                out_valid_reg, click_reg, cand_reg;
    logic [W-1:0]        old_reg, med_reg, centre_reg;
    logic [AW-1:0]       lo_reg, hi_reg;
    logic                mark_lo_reg, mark_hi_reg;
    logic [CW-1:0]       cnt_reg;
    logic [DW-1:0]       mad_reg;
    logic                upd_phase_reg;
    logic signed [W-1:0] y_sat;
    logic signed [51:0]  acc_r;
    logic signed [31:0]  acc_sh;

    // window ring: one write, one read per cycle
    logic [W-1:0] ram_rd;
    logic [AW-1:0] ram_raddr;
    logic          ram_we;
    mad_ram #(.WIDTH(W), .DEPTH(N)) u_win (
        .clk(clk), .we(ram_we), .waddr(wptr_reg), .wdata(y_sat),
        .raddr(ram_raddr), .rdata(ram_rd)
    );

    // sorted row
    row_ctrl_t     ctrl;
    logic [W-1:0]  row_key;
    logic [W-1:0]  vals [N];
    mad_row #(.W(W), .N(N)) u_row (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .key(row_key), .vals(vals)
    );

    // filter: one product per cycle, sequenced by tap_reg
    logic signed [COEF_BITS-1:0] cf;
    logic signed [W-1:0]         tv;
    logic signed [COEF_BITS+W-1:0] prod;
    always_comb
    begin
        case (tap_reg)
            3'd0: begin cf = b0_reg; tv = x_reg; end
            3'd1: begin cf = b1_reg; tv = x1_reg; end
            3'd2: begin cf = b2_reg; tv = x2_reg; end
            3'd3: begin cf = a1_reg; tv = y1_reg; end
            default: begin cf = a2_reg; tv = y2_reg; end
        endcase
    end
    assign prod = cf * tv;

    always_comb
    begin
        acc_r  = acc_reg + 52'sd524288;
        acc_sh = 32'(acc_r >>> 20);
        if (acc_sh > $signed(32'((1 << (W-1)) - 1)))
            y_sat = W'((1 << (W-1)) - 1);
        else if (acc_sh < -$signed(32'(1 << (W-1))))
            y_sat = W'(1 << (W-1));
        else
            y_sat = acc_sh[W-1:0];
    end

    // deviation of sorted entries from the median
    logic signed [DW-1:0] dlo, dhi;
    assign dlo = $signed({med_reg[W-1], med_reg}) - $signed({vals[lo_reg][W-1], vals[lo_reg]});
    assign dhi = $signed({vals[hi_reg][W-1], vals[hi_reg]}) - $signed({med_reg[W-1], med_reg});
    logic lo_ok, hi_ok, take_lo;
    assign lo_ok = (lo_reg != '0) || !mark_lo_reg;
    assign hi_ok = (hi_reg != AW'(N-1)) || !mark_hi_reg;
    assign take_lo = lo_ok && (!hi_ok || (dlo <= dhi));

    logic signed [DW-1:0] dc;
    logic [DW-1:0] dev;
    assign dc  = $signed({centre_reg[W-1], centre_reg}) - $signed({med_reg[W-1], med_reg});
    assign dev = dc[DW-1] ? DW'(-dc) : DW'(dc);
    logic [W-1:0] mag;
    assign mag = centre_reg[W-1] ? W'(-$signed(centre_reg)) : centre_reg;
    logic cand;
    assign cand = (PW'({dev, 8'd0}) > PW'(thr_reg) * PW'(mad_reg));
    logic [ENERGY_BITS:0] esum;
    assign esum = (ENERGY_BITS+1)'(ren_reg) + (ENERGY_BITS+1)'(mag);

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign ram_raddr = (state_reg == ST_FILT)
        ? ((wptr_reg >= AW'(HALF_WINDOW)) ? AW'(wptr_reg - AW'(HALF_WINDOW))
                                          : AW'(wptr_reg + AW'(HALF_WINDOW+1)))
        : wptr_reg;
    assign ram_we = (state_reg == ST_UPD) && !upd_phase_reg;

    always_comb
    begin
        ctrl = '0;
        row_key = y_sat;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = ST_FILT;
            ST_FILT: if (tap_reg == 3'd4) state_next = ST_UPD;
            ST_UPD:
            begin
                if (!upd_phase_reg)
                begin
                    row_key = old_reg;
                    ctrl.remove = (fill_reg == CW'(N));
                end
                else
                begin
                    ctrl.insert = 1'b1;
                    state_next = (fill_reg == CW'(N)) ? ST_MED : ST_OUT;
                end
            end
            ST_MED: state_next = ST_MAD;
            ST_MAD: if (cnt_reg == CW'(HALF_WINDOW)) state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            x_reg <= '0; acc_reg <= '0;
            x1_reg <= '0; x2_reg <= '0; y1_reg <= '0; y2_reg <= '0;
            wptr_reg <= '0; fill_reg <= '0;
            run_reg <= 1'b0; rlen_reg <= '0; ren_reg <= '0;
            out_valid_reg <= 1'b0; upd_phase_reg <= 1'b0;
            click_reg <= 1'b0; cand_reg <= 1'b0;
            old_reg <= '0; med_reg <= '0;
            lo_reg <= '0; hi_reg <= '0;
            mark_lo_reg <= 1'b0; mark_hi_reg <= 1'b0;
            cnt_reg <= '0; mad_reg <= '0;
            tap_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_axis_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    tap_reg <= '0;
                    acc_reg <= '0;
                    x_reg   <= s_axis_tdata[W-1:0];
                    // keep the pending result stable until a new sample arrives
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        click_reg <= 1'b0;
                        cand_reg  <= 1'b0;
                    end
                end
                ST_FILT:
                begin
                    tap_reg <= tap_reg + 3'd1;
                    if (tap_reg < 3'd3) acc_reg <= acc_reg + 52'(prod);
                    else acc_reg <= acc_reg - 52'(prod);
                    // oldest entry, read while idle
                    if (tap_reg == 3'd0) old_reg <= ram_rd;
                    upd_phase_reg <= 1'b0;
                end
                ST_UPD:
                begin
                    if (!upd_phase_reg)
                    begin
                        upd_phase_reg <= 1'b1;
                        x2_reg <= x1_reg; x1_reg <= x_reg;
                        y2_reg <= y1_reg; y1_reg <= y_sat;
                    end
                    else
                    begin
                        wptr_reg <= (wptr_reg == AW'(N-1)) ? '0 : AW'(wptr_reg + 1'b1);
                        if (fill_reg != CW'(N)) fill_reg <= fill_reg + 1'b1;
                    end
                end
                ST_MED:
                begin
                    med_reg <= vals[HALF_WINDOW];
                    lo_reg <= AW'(HALF_WINDOW);
                    hi_reg <= AW'(HALF_WINDOW);
                    mark_lo_reg <= 1'b0;
                    mark_hi_reg <= 1'b0;
                    cnt_reg <= '0;
                end
                ST_MAD:
                begin
                    // walk outward from the median in order of deviation
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == '0)
                    begin
                        mad_reg <= '0;
                        if (lo_reg != '0) lo_reg <= lo_reg - 1'b1; else mark_lo_reg <= 1'b1;
                        if (hi_reg != AW'(N-1)) hi_reg <= hi_reg + 1'b1; else mark_hi_reg <= 1'b1;
                    end
                    else if (take_lo)
                    begin
                        mad_reg <= dlo;
                        if (lo_reg != '0) lo_reg <= lo_reg - 1'b1; else mark_lo_reg <= 1'b1;
                    end
                    else
                    begin
                        mad_reg <= dhi;
                        if (hi_reg != AW'(N-1)) hi_reg <= hi_reg + 1'b1; else mark_hi_reg <= 1'b1;
                    end
                end
                ST_DECIDE:
                begin
                    cand_reg <= cand;
                    if (cand)
                    begin
                        if (!run_reg)
                        begin
                            run_reg <= 1'b1; rlen_reg <= 8'd1;
                            ren_reg <= ENERGY_BITS'(mag);
                        end
                        else if ((9'(rlen_reg) + 9'd1) > 9'(maxrun_reg))
                        begin
                            run_reg <= 1'b0; rlen_reg <= '0; ren_reg <= '0;
                        end
                        else
                        begin
                            rlen_reg <= rlen_reg + 1'b1;
                            ren_reg <= esum[ENERGY_BITS] ? '1 : esum[ENERGY_BITS-1:0];
                        end
                    end
                    else if (run_reg)
                    begin
                        click_reg <= !((minen_reg != '0) && (ren_reg < minen_reg));
                        run_reg <= 1'b0; rlen_reg <= '0; ren_reg <= '0;
                    end
                end
                ST_OUT: out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // centre sample (HALF_WINDOW-th oldest after write) read during filtering
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FILT && tap_reg == 3'd1) centre_reg <= ram_rd;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, cand_reg, click_reg};

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result pending");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");
    a_click_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && !cand) |=> !run_reg)
        else $error("run survived non-candidate");
    a_click_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("click and candidate together");
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (rlen_reg != '0))
        else $error("open run with zero length");
endmodule
`default_nettype wire

// ----- rtl/core/mad_ram.sv -----
`default_nettype none
module mad_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
